// ===== sv/hufd_pkg.sv =====
// Shared types, constants and the UTF-8 packing function of the Huffman tree decoder.
`default_nettype none
package hufd_pkg;

    localparam int SYM_W      = 21;
    localparam int LEN_W      = 6;
    localparam int CODE_W     = 32;
    localparam int LIMIT_W    = 31;
    localparam int BYTE_W     = 8;
    localparam int ACT_W      = 2;
    localparam int S_DATA_W   = 136;
    localparam int M_DATA_W   = 64;
    localparam int UTF_LEN_W  = 3;
    localparam int STATUS_W   = 2;

    // Values of the action selector on the input stream.
    localparam logic [ACT_W-1:0] ACT_LOAD  = 2'd0;
    localparam logic [ACT_W-1:0] ACT_START = 2'd1;
    localparam logic [ACT_W-1:0] ACT_DATA  = 2'd2;

    // Result status codes.
    localparam logic [STATUS_W-1:0] ST_SYMBOL  = 2'd0;
    localparam logic [STATUS_W-1:0] ST_MISSING = 2'd1;
    localparam logic [STATUS_W-1:0] ST_FULL    = 2'd2;

    typedef enum logic [1:0] {
        K_LOAD  = 2'd0,
        K_START = 2'd1,
        K_DATA  = 2'd2,
        K_NOP   = 2'd3
    } kind_t;

    typedef struct packed {
        kind_t               kind;
        logic [SYM_W-1:0]    symbol;
        logic [LEN_W-1:0]    code_length;
        logic [CODE_W-1:0]   code_bits;
        logic [LIMIT_W-1:0]  byte_limit;
        logic [LIMIT_W-1:0]  symbol_limit;
        logic [BYTE_W-1:0]   data_byte;
    } cmd_t;

    typedef struct packed {
        logic [SYM_W-1:0]     code_point;
        logic [31:0]          utf8_bytes;
        logic [UTF_LEN_W-1:0] utf8_length;
        logic [STATUS_W-1:0]  status;
        logic                 stream_done;
    } res_t;

    // Builds one result; error results carry no code point and no bytes.
    function automatic res_t make_res(input logic [SYM_W-1:0] cp,
                                      input logic [STATUS_W-1:0] status,
                                      input logic done);
        res_t r;
        r.code_point  = '0;
        r.utf8_bytes  = '0;
        r.utf8_length = '0;
        r.status      = status;
        r.stream_done = done;
        if (status == ST_SYMBOL)
        begin
            r.code_point = cp;
            if (cp < 21'h80)
            begin
                r.utf8_length = 3'd1;
                r.utf8_bytes  = {25'd0, cp[6:0]};
            end
            else if (cp < 21'h800)
            begin
                r.utf8_length = 3'd2;
                r.utf8_bytes  = {16'd0, 2'b10, cp[5:0], 3'b110, cp[10:6]};
            end
            else if (cp < 21'h10000)
            begin
                r.utf8_length = 3'd3;
                r.utf8_bytes  = {8'd0, 2'b10, cp[5:0], 2'b10, cp[11:6],
                                 4'b1110, cp[15:12]};
            end
            else
            begin
                r.utf8_length = 3'd4;
                r.utf8_bytes  = {2'b10, cp[5:0], 2'b10, cp[11:6], 2'b10, cp[17:12],
                                 5'b11110, cp[20:18]};
            end
        end
        return r;
    endfunction

endpackage
`default_nettype wire

// ===== sv/hufd_ram.sv =====
// Generic single write port, single read port RAM with registered read data.
`default_nettype none
module hufd_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  wire logic                     clk,
    input  wire logic                     we,
    input  wire logic [$clog2(DEPTH)-1:0] waddr,
    input  wire logic [WIDTH-1:0]         wdata,
    input  wire logic                     re,
    input  wire logic [$clog2(DEPTH)-1:0] raddr,
    output logic      [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata <= mem[raddr];
        end
    end

endmodule
`default_nettype wire

// ===== sv/hufd_front.sv =====
// Front end: accepts requests, classifies them and queues them for the tree engine.
`default_nettype none
module hufd_front #(
    parameter int MAX_CODE_LEN = 32
) (
    input  wire logic                           clk,
    input  wire logic                           rst_n,
    input  wire logic                           s_tvalid,
    output logic                                s_tready,
    input  wire logic [hufd_pkg::ACT_W-1:0]     s_tuser,
    input  wire logic [hufd_pkg::S_DATA_W-1:0]  s_tdata,
    output logic                                cmd_valid,
    input  wire logic                           cmd_ready,
    output hufd_pkg::cmd_t                      cmd
);
    import hufd_pkg::*;

    cmd_t       fifo_reg [2];
    logic       wr_ptr_reg, wr_ptr_next;
    logic       rd_ptr_reg, rd_ptr_next;
    logic [1:0] count_reg, count_next;
    cmd_t       in_cmd;
    logic       push, pop;

    always_comb
    begin
        in_cmd.symbol       = s_tdata[20:0];
        in_cmd.code_length  = s_tdata[26:21];
        in_cmd.code_bits    = s_tdata[58:27];
        in_cmd.byte_limit   = s_tdata[89:59];
        in_cmd.symbol_limit = s_tdata[120:90];
        in_cmd.data_byte    = s_tdata[128:121];
        // Codes longer than the tree depth are cut to the maximum length.
        if (s_tdata[26:21] > LEN_W'(MAX_CODE_LEN))
        begin
            in_cmd.code_length = LEN_W'(MAX_CODE_LEN);
        end
        unique case (s_tuser)
            ACT_LOAD:  in_cmd.kind = K_LOAD;
            ACT_START: in_cmd.kind = K_START;
            ACT_DATA:  in_cmd.kind = K_DATA;
            default:   in_cmd.kind = K_NOP;
        endcase
    end

    assign s_tready  = (count_reg != 2'd2);
    assign cmd_valid = (count_reg != 2'd0);
    assign cmd       = fifo_reg[rd_ptr_reg];
    assign push      = s_tvalid && s_tready;
    assign pop       = cmd_valid && cmd_ready;

    always_comb
    begin
        wr_ptr_next = push ? ~wr_ptr_reg : wr_ptr_reg;
        rd_ptr_next = pop ? ~rd_ptr_reg : rd_ptr_reg;
        count_next  = count_reg + 2'(push) - 2'(pop);
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            fifo_reg[wr_ptr_reg] <= in_cmd;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            count_reg  <= 2'd0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

endmodule
`default_nettype wire

// ===== sv/hufd_back.sv =====
// Back end: walks the node table for loads and data bytes and drives the result stream.
`default_nettype none
module hufd_back #(
    parameter int MAX_NODES = 1024
) (
    input  wire logic                           clk,
    input  wire logic                           rst_n,
    input  wire logic                           cmd_valid,
    output logic                                cmd_ready,
    input  wire hufd_pkg::cmd_t                 cmd,
    output logic                                m_tvalid,
    input  wire logic                           m_tready,
    output logic [hufd_pkg::M_DATA_W-1:0]       m_tdata,
    output logic [hufd_pkg::STATUS_W-1:0]       m_tuser,
    output logic                                m_tlast
);
    import hufd_pkg::*;

    localparam int NW = $clog2(MAX_NODES);
    localparam int EW = 2 * NW + SYM_W;

    typedef enum logic [8:0] {
        S_IDLE = 9'b000000001,
        S_L_RD = 9'b000000010,
        S_L_ST = 9'b000000100,
        S_L_AL = 9'b000001000,
        S_D_RD = 9'b000010000,
        S_D_LD = 9'b000100000,
        S_D_ST = 9'b001000000,
        S_D_CK = 9'b010000000,
        S_D_END = 9'b100000000
    } state_t;

    state_t              state_reg, state_next;
    logic [NW-1:0]       root_l_reg, root_l_next;
    logic [NW-1:0]       root_r_reg, root_r_next;
    logic [SYM_W-1:0]    root_s_reg, root_s_next;
    logic [NW:0]         free_reg, free_next;
    logic [NW-1:0]       node_reg, node_next;
    logic [NW-1:0]       cur_reg, cur_next;
    logic [NW-1:0]       child_reg, child_next;
    logic [LIMIT_W-1:0]  bytes_reg, bytes_next;
    logic [LIMIT_W-1:0]  syms_reg, syms_next;
    logic [SYM_W-1:0]    sym_reg, sym_next;
    logic [CODE_W-1:0]   code_reg, code_next;
    logic [LEN_W-1:0]    rem_reg, rem_next;
    logic [BYTE_W-1:0]   data_reg, data_next;
    logic [2:0]          bidx_reg, bidx_next;
    logic [EW-1:0]       ent_reg, ent_next;
    logic                pend_valid_reg, pend_valid_next;
    res_t                pend_reg, pend_next;
    logic                out_valid_reg, out_valid_next;
    res_t                out_reg, out_next;
    logic                out_last_reg, out_last_next;

    logic                ram_we, ram_re;
    logic [NW-1:0]       ram_waddr, ram_raddr;
    logic [EW-1:0]       ram_wdata, ram_rdata;

    logic                slot_free, can_emit, push;
    logic [NW-1:0]       e_l, e_r, r_l, r_r, slot;
    logic [SYM_W-1:0]    r_s;
    logic                bit_v;
    logic [LIMIT_W-1:0]  syms_dec;

    hufd_ram #(.WIDTH(EW), .DEPTH(MAX_NODES)) u_nodes (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .re    (ram_re),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

    assign r_l       = ram_rdata[EW-1 -: NW];
    assign r_r       = ram_rdata[SYM_W +: NW];
    assign r_s       = ram_rdata[SYM_W-1:0];
    assign slot_free = !out_valid_reg || m_tready;
    assign can_emit  = !pend_valid_reg || slot_free;
    assign syms_dec  = syms_reg - LIMIT_W'(1);

    always_comb
    begin
        state_next      = state_reg;
        root_l_next     = root_l_reg;
        root_r_next     = root_r_reg;
        root_s_next     = root_s_reg;
        free_next       = free_reg;
        node_next       = node_reg;
        cur_next        = cur_reg;
        child_next      = child_reg;
        bytes_next      = bytes_reg;
        syms_next       = syms_reg;
        sym_next        = sym_reg;
        code_next       = code_reg;
        rem_next        = rem_reg;
        data_next       = data_reg;
        bidx_next       = bidx_reg;
        ent_next        = ent_reg;
        pend_valid_next = pend_valid_reg;
        pend_next       = pend_reg;
        out_valid_next  = out_valid_reg && !m_tready;
        out_next        = out_reg;
        out_last_next   = out_last_reg;
        push            = 1'b0;
        cmd_ready       = 1'b0;
        ram_we          = 1'b0;
        ram_waddr       = node_reg;
        ram_wdata       = '0;
        ram_re          = 1'b0;
        ram_raddr       = node_reg;
        e_l             = root_l_reg;
        e_r             = root_r_reg;
        slot            = '0;
        bit_v           = 1'b0;

        unique case (state_reg)
            S_IDLE:
            begin
                cmd_ready = 1'b1;
                if (cmd_valid)
                begin
                    unique case (cmd.kind)
                        K_LOAD:
                        begin
                            node_next  = '0;
                            rem_next   = cmd.code_length;
                            sym_next   = cmd.symbol;
                            code_next  = cmd.code_bits;
                            state_next = S_L_RD;
                        end
                        K_START:
                        begin
                            bytes_next = cmd.byte_limit;
                            syms_next  = cmd.symbol_limit;
                            cur_next   = '0;
                        end
                        K_DATA:
                        begin
                            if (bytes_reg != '0 && syms_reg != '0)
                            begin
                                bytes_next = bytes_reg - LIMIT_W'(1);
                                data_next  = cmd.data_byte;
                                bidx_next  = 3'd7;
                                state_next = S_D_RD;
                            end
                        end
                        K_NOP:
                        begin
                        end
                        default:
                        begin
                        end
                    endcase
                end
            end

            S_L_RD:
            begin
                ram_re     = (node_reg != '0);
                ram_raddr  = node_reg;
                state_next = S_L_ST;
            end

            S_L_ST:
            begin
                if (node_reg != '0)
                begin
                    e_l = r_l;
                    e_r = r_r;
                end
                if (rem_reg == '0)
                begin
                    if (node_reg == '0)
                    begin
                        root_s_next = sym_reg;
                    end
                    else
                    begin
                        ram_we    = 1'b1;
                        ram_waddr = node_reg;
                        ram_wdata = {e_l, e_r, sym_reg};
                    end
                    state_next = S_IDLE;
                end
                else
                begin
                    bit_v = code_reg[5'(rem_reg - LEN_W'(1))];
                    slot  = bit_v ? e_r : e_l;
                    if (slot != '0)
                    begin
                        node_next  = slot;
                        rem_next   = rem_reg - LEN_W'(1);
                        state_next = S_L_RD;
                    end
                    else if (free_reg >= (NW+1)'(MAX_NODES))
                    begin
                        // Table full: report once and drop the rest of the code.
                        if (slot_free)
                        begin
                            push          = 1'b1;
                            out_next      = make_res('0, ST_FULL,
                                                     bytes_reg == '0 || syms_reg == '0);
                            out_last_next = 1'b1;
                            state_next    = S_IDLE;
                        end
                    end
                    else
                    begin
                        if (node_reg == '0)
                        begin
                            if (bit_v)
                            begin
                                root_r_next = free_reg[NW-1:0];
                            end
                            else
                            begin
                                root_l_next = free_reg[NW-1:0];
                            end
                        end
                        else
                        begin
                            ram_we    = 1'b1;
                            ram_waddr = node_reg;
                            ram_wdata = bit_v ? {e_l, free_reg[NW-1:0], r_s}
                                              : {free_reg[NW-1:0], e_r, r_s};
                        end
                        state_next = S_L_AL;
                    end
                end
            end

            S_L_AL:
            begin
                ram_we     = 1'b1;
                ram_waddr  = free_reg[NW-1:0];
                ram_wdata  = '0;
                node_next  = free_reg[NW-1:0];
                free_next  = free_reg + (NW+1)'(1);
                rem_next   = rem_reg - LEN_W'(1);
                state_next = S_L_RD;
            end

            S_D_RD:
            begin
                ram_re     = (cur_reg != '0);
                ram_raddr  = cur_reg;
                state_next = S_D_LD;
            end

            S_D_LD:
            begin
                if (cur_reg != '0)
                begin
                    ent_next = ram_rdata;
                end
                state_next = S_D_ST;
            end

            S_D_ST:
            begin
                if (cur_reg != '0)
                begin
                    e_l = ent_reg[EW-1 -: NW];
                    e_r = ent_reg[SYM_W +: NW];
                end
                bit_v = data_reg[bidx_reg];
                slot  = bit_v ? e_r : e_l;
                if (slot == '0)
                begin
                    if (can_emit)
                    begin
                        if (pend_valid_reg)
                        begin
                            push          = 1'b1;
                            out_next      = pend_reg;
                            out_last_next = 1'b0;
                        end
                        pend_valid_next = 1'b1;
                        pend_next       = make_res('0, ST_MISSING, 1'b0);
                        cur_next        = '0;
                        if (bidx_reg == 3'd0)
                        begin
                            state_next = S_D_END;
                        end
                        else
                        begin
                            bidx_next = bidx_reg - 3'd1;
                        end
                    end
                end
                else
                begin
                    ram_re     = 1'b1;
                    ram_raddr  = slot;
                    child_next = slot;
                    state_next = S_D_CK;
                end
            end

            S_D_CK:
            begin
                if (r_l == '0 && r_r == '0)
                begin
                    if (can_emit)
                    begin
                        if (pend_valid_reg)
                        begin
                            push          = 1'b1;
                            out_next      = pend_reg;
                            out_last_next = 1'b0;
                        end
                        pend_valid_next = 1'b1;
                        pend_next       = make_res(r_s, ST_SYMBOL, syms_dec == '0);
                        syms_next       = syms_dec;
                        cur_next        = '0;
                        if (bidx_reg == 3'd0 || syms_dec == '0)
                        begin
                            state_next = S_D_END;
                        end
                        else
                        begin
                            bidx_next  = bidx_reg - 3'd1;
                            state_next = S_D_ST;
                        end
                    end
                end
                else
                begin
                    cur_next = child_reg;
                    ent_next = ram_rdata;
                    if (bidx_reg == 3'd0)
                    begin
                        state_next = S_D_END;
                    end
                    else
                    begin
                        bidx_next  = bidx_reg - 3'd1;
                        state_next = S_D_ST;
                    end
                end
            end

            S_D_END:
            begin
                if (!pend_valid_reg)
                begin
                    state_next = S_IDLE;
                end
                else if (slot_free)
                begin
                    push                 = 1'b1;
                    out_next             = pend_reg;
                    out_next.stream_done = (bytes_reg == '0 || syms_reg == '0);
                    out_last_next        = 1'b1;
                    pend_valid_next      = 1'b0;
                    state_next           = S_IDLE;
                end
            end

            default:
            begin
                state_next = S_IDLE;
            end
        endcase

        if (push)
        begin
            out_valid_next = 1'b1;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tlast  = out_last_reg;
    assign m_tuser  = out_reg.status;
    assign m_tdata  = {7'd0, out_reg.stream_done, out_reg.utf8_length,
                       out_reg.utf8_bytes, out_reg.code_point};

    always_ff @(posedge clk)
    begin
        node_reg  <= node_next;
        child_reg <= child_next;
        sym_reg   <= sym_next;
        code_reg  <= code_next;
        rem_reg   <= rem_next;
        data_reg  <= data_next;
        bidx_reg  <= bidx_next;
        ent_reg   <= ent_next;
        pend_reg  <= pend_next;
        out_reg   <= out_next;
        out_last_reg <= out_last_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= S_IDLE;
            root_l_reg     <= '0;
            root_r_reg     <= '0;
            root_s_reg     <= '0;
            free_reg       <= (NW+1)'(1);
            cur_reg        <= '0;
            bytes_reg      <= '0;
            syms_reg       <= '0;
            pend_valid_reg <= 1'b0;
            out_valid_reg  <= 1'b0;
        end
        else
        begin
            state_reg      <= state_next;
            root_l_reg     <= root_l_next;
            root_r_reg     <= root_r_next;
            root_s_reg     <= root_s_next;
            free_reg       <= free_next;
            cur_reg        <= cur_next;
            bytes_reg      <= bytes_next;
            syms_reg       <= syms_next;
            pend_valid_reg <= pend_valid_next;
            out_valid_reg  <= out_valid_next;
        end
    end

    // The root lives in flip-flops, so the table memory never takes a write there.
    a_no_root_write: assert property (@(posedge clk) disable iff (!rst_n)
        ram_we |-> ram_waddr != '0)
        else $error("node table write to the root address");

    a_free_bound: assert property (@(posedge clk) disable iff (!rst_n)
        free_reg <= (NW+1)'(MAX_NODES) && free_reg != '0)
        else $error("free node counter out of range");

    a_push_room: assert property (@(posedge clk) disable iff (!rst_n)
        push |-> (!out_valid_reg || m_tready))
        else $error("result pushed over an untaken result");

    a_pending_flushed: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_IDLE) |-> !pend_valid_reg)
        else $error("held result left behind after a data byte");

endmodule
`default_nettype wire

// ===== sv/huffman_tree_decoder_utf8.sv =====
// Top level of the Huffman tree decoder with UTF-8 output.
//
// Channel  Dir  Fields (lowest bit first)
// s_*      in   tuser: action; tdata: symbol, code_length, code_bits,
//               byte_limit, symbol_limit, data_byte
// m_*      out  tuser: status; tdata: code_point, utf8_bytes, utf8_length,
//               stream_done; tlast: last
//
// A start request is handled in the idle state of the engine. A load request is
// taken in the idle state, then runs a read and a step state per tree level and an
// allocate state per node it creates; each level below the root is one registered
// read of the node table RAM. A data byte is taken in idle and set up in a read and
// a load state; each bit then takes the step state, plus a check state that reads
// and tests the child when it reaches one, and a closing state ends the byte.
// A two-entry request queue lets new requests arrive while a byte is decoded.
// The engine stalls only when a result is waiting and the output register is
// still occupied. Reset clears the root node, counters and all valid flags; the
// rest of the node table is written as nodes are allocated and needs no clearing.
`default_nettype none
module huffman_tree_decoder_utf8 #(
    parameter int MAX_NODES    = 1024,
    parameter int MAX_CODE_LEN = 32
) (
    input  wire logic                           clk,
    input  wire logic                           rst_n,
    input  wire logic                           s_tvalid,
    output logic                                s_tready,
    // action
    input  wire logic [hufd_pkg::ACT_W-1:0]     s_tuser,
    // symbol, code_length, code_bits, byte_limit, symbol_limit, data_byte
    input  wire logic [hufd_pkg::S_DATA_W-1:0]  s_tdata,
    output logic                                m_tvalid,
    input  wire logic                           m_tready,
    // code_point, utf8_bytes, utf8_length, stream_done
    output logic [hufd_pkg::M_DATA_W-1:0]       m_tdata,
    // status
    output logic [hufd_pkg::STATUS_W-1:0]       m_tuser,
    output logic                                m_tlast
);
    import hufd_pkg::*;

    logic cmd_valid;
    logic cmd_ready;
    cmd_t cmd;

    // Front end: decode the action and queue the request.
    hufd_front #(.MAX_CODE_LEN(MAX_CODE_LEN)) u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tuser   (s_tuser),
        .s_tdata   (s_tdata),
        .cmd_valid (cmd_valid),
        .cmd_ready (cmd_ready),
        .cmd       (cmd)
    );

    // Back end: tree walks, stream counters and the result register.
    hufd_back #(.MAX_NODES(MAX_NODES)) u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .cmd_valid (cmd_valid),
        .cmd_ready (cmd_ready),
        .cmd       (cmd),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tuser   (m_tuser),
        .m_tlast   (m_tlast)
    );

endmodule
`default_nettype wire
